// ===== hdl/bid_pkg.sv =====
`default_nettype none
package bid_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int FUNC_W     = 4;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MAXI_W     = 8;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FN_PUSH_FRONT = 4'd0;
    localparam func_t FN_PUSH_BACK  = 4'd1;
    localparam func_t FN_POP_FRONT  = 4'd2;
    localparam func_t FN_POP_BACK   = 4'd3;
    localparam func_t FN_INSERT     = 4'd4;
    localparam func_t FN_DELETE_AT  = 4'd5;
    localparam func_t FN_CLEAR      = 4'd6;
    localparam func_t FN_READ       = 4'd7;
    localparam func_t FN_WRITE      = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_BOUND_ON      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INDEX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VALUE = 2'd2;

    // Physical address of logical position idx, wrapping around the store.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] idx);
        slot = head + idx[AW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bid_if.sv =====
`default_nettype none
interface bid_req_if;
    logic                          valid;
    logic                          ready;
    bid_pkg::func_t                func;
    logic signed [bid_pkg::POS_W-1:0] position;
    logic                          position_unknown;
    logic [bid_pkg::DATA_WIDTH-1:0] write_data;

    modport source (output valid, func, position, position_unknown, write_data, input ready);
    modport sink   (input valid, func, position, position_unknown, write_data, output ready);
endinterface

interface bid_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bid_pkg::DATA_WIDTH-1:0] read_data;
    logic                           hit;
    logic [bid_pkg::CW-1:0]         count;
    logic                           overflow;

    modport source (output valid, read_data, hit, count, overflow, input ready);
    modport sink   (input valid, read_data, hit, count, overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/bounded_indexed_deque.sv =====
`default_nettype none
// Bounded double-ended queue of 32-bit words held in a 256-entry single-read,
// single-write RAM. One word is accepted at a time; its result word follows
// in an output register. Push front, write in range, clear and operations that
// change nothing go straight to the result, as does a push or insert whose new
// word falls past the limit. Pops and reads that find an element first make one
// RAM read. Push back, insert, append and delete move entries one at a time,
// each move being a RAM read followed by a RAM write. While the previous result
// word waits for ready, a finished result holds and no new word is accepted.
// No clearing pass is needed after reset.
module bounded_indexed_deque (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bid_pkg::CFG_DATA_W-1:0] cfg_data,
    bid_req_if.sink                             req,
    bid_rsp_if.source                           rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_RDWAIT, S_GROW, S_GROW_WR, S_DEL, S_DEL_WR, S_DONE
    } state_t;

    localparam int AW = bid_pkg::AW;
    localparam int CW = bid_pkg::CW;
    localparam int DW = bid_pkg::DATA_WIDTH;

    state_t          state_reg;
    logic [AW-1:0]   head_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   pos_reg;
    logic [DW-1:0]   data_reg;
    logic            bound_on_reg;
    logic [bid_pkg::MAXI_W-1:0] max_index_reg;
    logic [DW-1:0]   default_reg;
    logic [DW-1:0]   res_rdata_reg;
    logic            res_hit_reg;
    logic            res_ovf_reg;
    logic            out_valid_reg;
    logic [DW-1:0]   out_rdata_reg;
    logic            out_hit_reg;
    logic [CW-1:0]   out_count_reg;
    logic            out_ovf_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [DW-1:0]   ram_q;

    logic            accept;
    logic            known;
    logic [CW-1:0]   p;
    logic            p_le_count;
    logic            p_lt_count;
    logic [CW-1:0]   lim;
    logic [CW-1:0]   grown;
    logic [CW-1:0]   keep;
    logic            out_free;
    logic            out_load;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign out_load = (state_reg == S_DONE) && out_free;

    assign known      = !req.position_unknown && !req.position[bid_pkg::POS_W-1];
    assign p          = req.position[CW-1:0];
    assign p_le_count = known && (req.position[bid_pkg::POS_W-2:0]
                                  <= (bid_pkg::POS_W-1)'(count_reg));
    assign p_lt_count = known && (req.position[bid_pkg::POS_W-2:0]
                                  < (bid_pkg::POS_W-1)'(count_reg));

    assign lim   = bound_on_reg ? (CW'(max_index_reg) + CW'(1)) : CW'(bid_pkg::DEPTH);
    assign grown = count_reg + CW'(1);
    assign keep  = (grown > lim) ? lim : grown;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        bid_pkg::FN_PUSH_FRONT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = head_reg - AW'(1);
                            ram_wdata = req.write_data;
                        end
                        bid_pkg::FN_POP_FRONT:
                        begin
                            ram_re    = (count_reg != '0);
                            ram_raddr = head_reg;
                        end
                        bid_pkg::FN_POP_BACK:
                        begin
                            ram_re    = (count_reg != '0);
                            ram_raddr = bid_pkg::slot(head_reg, count_reg - CW'(1));
                        end
                        bid_pkg::FN_READ:
                        begin
                            ram_re    = p_lt_count;
                            ram_raddr = bid_pkg::slot(head_reg, p);
                        end
                        bid_pkg::FN_WRITE:
                        begin
                            ram_we    = p_lt_count;
                            ram_waddr = bid_pkg::slot(head_reg, p);
                            ram_wdata = req.write_data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_GROW:
            begin
                if (idx_reg > pos_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = bid_pkg::slot(head_reg, idx_reg - CW'(1));
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = bid_pkg::slot(head_reg, pos_reg);
                    ram_wdata = data_reg;
                end
            end
            S_GROW_WR, S_DEL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = bid_pkg::slot(head_reg, idx_reg);
                ram_wdata = ram_q;
            end
            S_DEL:
            begin
                ram_re    = (idx_reg < count_reg);
                ram_raddr = bid_pkg::slot(head_reg, idx_reg + CW'(1));
            end
            default:
            begin
            end
        endcase
    end

    bid_ram #(.AW(AW), .DW(DW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .q     (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_on_reg  <= 1'b0;
            max_index_reg <= '1;
            default_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bid_pkg::REG_BOUND_ON:      bound_on_reg  <= cfg_data[0];
                bid_pkg::REG_MAX_INDEX:     max_index_reg <= cfg_data[bid_pkg::MAXI_W-1:0];
                bid_pkg::REG_DEFAULT_VALUE: default_reg   <= cfg_data[DW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            data_reg      <= '0;
            res_rdata_reg <= '0;
            res_hit_reg   <= 1'b0;
            res_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_rdata_reg <= '0;
            out_hit_reg   <= 1'b0;
            out_count_reg <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_rdata_reg <= '0;
                        res_hit_reg   <= 1'b0;
                        res_ovf_reg   <= 1'b0;
                        data_reg      <= req.write_data;
                        state_reg     <= S_DONE;
                        case (req.func)
                            bid_pkg::FN_PUSH_FRONT:
                            begin
                                head_reg    <= head_reg - AW'(1);
                                count_reg   <= keep;
                                res_hit_reg <= 1'b1;
                                res_ovf_reg <= (grown > lim);
                            end
                            bid_pkg::FN_PUSH_BACK:
                            begin
                                pos_reg     <= count_reg;
                                idx_reg     <= keep - CW'(1);
                                count_reg   <= keep;
                                res_hit_reg <= (count_reg < keep);
                                res_ovf_reg <= (grown > lim);
                                if (count_reg < keep)
                                begin
                                    state_reg <= S_GROW;
                                end
                            end
                            bid_pkg::FN_POP_FRONT, bid_pkg::FN_POP_BACK:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_rdata_reg <= default_reg;
                                end
                                else
                                begin
                                    if (req.func == bid_pkg::FN_POP_FRONT)
                                    begin
                                        head_reg <= head_reg + AW'(1);
                                    end
                                    count_reg   <= count_reg - CW'(1);
                                    res_hit_reg <= 1'b1;
                                    state_reg   <= S_RDWAIT;
                                end
                            end
                            bid_pkg::FN_INSERT:
                            begin
                                if (p_le_count)
                                begin
                                    pos_reg     <= p;
                                    idx_reg     <= keep - CW'(1);
                                    count_reg   <= keep;
                                    res_hit_reg <= (p < keep);
                                    res_ovf_reg <= (grown > lim);
                                    if (p < keep)
                                    begin
                                        state_reg <= S_GROW;
                                    end
                                end
                            end
                            bid_pkg::FN_DELETE_AT:
                            begin
                                if (p_lt_count)
                                begin
                                    idx_reg     <= p;
                                    count_reg   <= count_reg - CW'(1);
                                    res_hit_reg <= 1'b1;
                                    state_reg   <= S_DEL;
                                end
                            end
                            bid_pkg::FN_CLEAR:
                            begin
                                head_reg  <= '0;
                                count_reg <= '0;
                            end
                            bid_pkg::FN_READ:
                            begin
                                if (p_lt_count)
                                begin
                                    res_hit_reg <= 1'b1;
                                    state_reg   <= S_RDWAIT;
                                end
                                else
                                begin
                                    res_rdata_reg <= default_reg;
                                end
                            end
                            bid_pkg::FN_WRITE:
                            begin
                                if (p_lt_count)
                                begin
                                    res_hit_reg <= 1'b1;
                                end
                                else if (p_le_count)
                                begin
                                    // A write at the current count appends.
                                    pos_reg     <= p;
                                    idx_reg     <= keep - CW'(1);
                                    count_reg   <= keep;
                                    res_hit_reg <= (p < keep);
                                    res_ovf_reg <= (grown > lim);
                                    if (p < keep)
                                    begin
                                        state_reg <= S_GROW;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RDWAIT:
                begin
                    res_rdata_reg <= ram_q;
                    state_reg     <= S_DONE;
                end
                S_GROW:
                begin
                    state_reg <= (idx_reg > pos_reg) ? S_GROW_WR : S_DONE;
                end
                S_GROW_WR:
                begin
                    idx_reg   <= idx_reg - CW'(1);
                    state_reg <= S_GROW;
                end
                S_DEL:
                begin
                    state_reg <= (idx_reg < count_reg) ? S_DEL_WR : S_DONE;
                end
                S_DEL_WR:
                begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_DEL;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_rdata_reg <= res_rdata_reg;
                        out_hit_reg   <= res_hit_reg;
                        out_count_reg <= count_reg;
                        out_ovf_reg   <= res_ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_rdata_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.count     = out_count_reg;
    assign rsp.overflow  = out_ovf_reg;

endmodule
`default_nettype wire

// ===== hdl/bid_ram.sv =====
`default_nettype none
module bid_ram #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] q
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            q <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/bid_checker.sv =====
`default_nettype none
module bid_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [bid_pkg::DATA_WIDTH-1:0] out_read_data,
    input wire logic [bid_pkg::CW-1:0]         out_count,
    input wire logic                           out_overflow
);

    // Only one word is in flight, so ready drops right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is still in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_count))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count <= bid_pkg::CW'(bid_pkg::DEPTH))
        else $error("count above capacity");

    // A truncation always leaves the queue at a nonzero limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_overflow |-> out_count != '0)
        else $error("overflow reported with empty queue");

endmodule

bind bounded_indexed_deque bid_checker u_bid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_read_data (rsp.read_data),
    .out_count     (rsp.count),
    .out_overflow  (rsp.overflow)
);
`default_nettype wire
